// File: hw/rtl/ibma_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ibma_pkg
// Shared constants, codes, state type and path decode for the inode block
// map allocator.
// ----------------------------------------------------------------------------
package ibma_pkg;

   localparam int NODE_COUNT        = 64;
   localparam int NODE_W            = 6;
   localparam int BLOCK_W           = 12;
   localparam int POINTERS_PER_NODE = 32;
   localparam int SLOT_W            = 5;
   localparam int DIRECT_SLOTS      = 8;
   localparam int SINGLE_SLOTS      = 4;
   localparam int DOUBLE_SLOTS      = 1;
   localparam int CAPACITY          = DIRECT_SLOTS + SINGLE_SLOTS * POINTERS_PER_NODE +
                                      DOUBLE_SLOTS * POINTERS_PER_NODE * POINTERS_PER_NODE;
   localparam int CNT_W             = 11;
   localparam int LB_W              = 11;
   localparam int MAP_WORD_W        = 32;
   localparam int MAP_BIT_W         = 5;
   localparam int MAP_DEPTH         = 128;
   localparam int MAP_AW            = 7;
   localparam int PTR_DEPTH         = NODE_COUNT * POINTERS_PER_NODE;
   localparam int PTR_AW            = NODE_W + SLOT_W;
   localparam int PTR_DW            = BLOCK_W + 1;
   localparam int SCAN_W            = 7;

   localparam logic [1:0] CMD_CREATE = 2'd0;
   localparam logic [1:0] CMD_APPEND = 2'd1;
   localparam logic [1:0] CMD_LOOKUP = 2'd2;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_NO_BLOCK  = 3'd1;
   localparam logic [2:0] ST_NO_NODE   = 3'd2;
   localparam logic [2:0] ST_RANGE     = 3'd3;
   localparam logic [2:0] ST_NOT_INODE = 3'd4;

   localparam logic [1:0] KIND_UNUSED = 2'd0;
   localparam logic [1:0] KIND_INODE  = 2'd1;
   localparam logic [1:0] KIND_PNODE  = 2'd2;
   localparam logic [1:0] KIND_DNODE  = 2'd3;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_INFO_RD,
      S_INFO_CHK,
      S_BLK_RD,
      S_BLK_CHK,
      S_NODE_RD,
      S_NODE_CHK,
      S_WALK_RD,
      S_WALK_CHK,
      S_NODE_CLR,
      S_LINK,
      S_DATA,
      S_CR_COMMIT,
      S_CR_CLR,
      S_FIN
   } state_type;

   typedef struct packed {
      logic [1:0]        depth;
      logic [SLOT_W-1:0] slot0;
      logic [SLOT_W-1:0] slot1;
      logic [SLOT_W-1:0] slot2;
   } path_type;

   // split a logical block into the slot index at each level of the map
   function automatic path_type path_of(input logic [LB_W-1:0] t);
      path_type         p;
      logic [LB_W-1:0]  off;
      p   = '0;
      off = '0;
      if (t < LB_W'(DIRECT_SLOTS)) begin
         p.depth = 2'd1;
         p.slot0 = SLOT_W'(t);
      end else if (t < LB_W'(DIRECT_SLOTS + SINGLE_SLOTS * POINTERS_PER_NODE)) begin
         off     = t - LB_W'(DIRECT_SLOTS);
         p.depth = 2'd2;
         p.slot0 = SLOT_W'(DIRECT_SLOTS) + SLOT_W'(off >> SLOT_W);
         p.slot1 = off[SLOT_W-1:0];
      end else begin
         off     = t - LB_W'(DIRECT_SLOTS + SINGLE_SLOTS * POINTERS_PER_NODE);
         p.depth = 2'd3;
         p.slot0 = SLOT_W'(DIRECT_SLOTS + SINGLE_SLOTS);
         p.slot1 = off[2*SLOT_W-1:SLOT_W];
         p.slot2 = off[SLOT_W-1:0];
      end
      return p;
   endfunction

endpackage
`default_nettype wire

// File: hw/rtl/ibma_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ibma request and response channels
// Valid/ready channels carrying command items and result items.
// ----------------------------------------------------------------------------
interface ibma_req_if;
   logic                         valid;
   logic                         ready;
   logic [1:0]                   command;
   logic [ibma_pkg::NODE_W-1:0]  inode_index;
   logic [ibma_pkg::LB_W-1:0]    logical_block;

   modport source (output valid, command, inode_index, logical_block, input ready);
   modport sink   (input valid, command, inode_index, logical_block, output ready);
endinterface

interface ibma_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [ibma_pkg::BLOCK_W-1:0] physical_block;
   logic [ibma_pkg::NODE_W-1:0]  node_number;
   logic [2:0]                   status;

   modport source (output valid, physical_block, node_number, status, input ready);
   modport sink   (input valid, physical_block, node_number, status, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/ibma_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ibma_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module ibma_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW   = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// File: hw/rtl/ibma_ffz.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ibma_ffz
// Finds the lowest zero bit of a bitmap word.
// ----------------------------------------------------------------------------
module ibma_ffz #(
   parameter int WIDTH = 32,
   localparam int IW   = $clog2(WIDTH)
) (
   input  wire logic [WIDTH-1:0] word,
   output logic                  found,
   output logic      [IW-1:0]    index
);

   always_comb begin
      index = '0;
      for (int i = WIDTH - 1; i >= 0; i--) begin
         if (!word[i]) begin
            index = IW'(i);
         end
      end
   end

   assign found = ~&word;

endmodule
`default_nettype wire

// File: hw/rtl/inode_block_map_allocator_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// inode_block_map_allocator_core
// Inode block map with first-free bitmap and node allocator.
// ----------------------------------------------------------------------------
// One item is taken at a time; ready is high only while the sequencer idles.
// After reset a clearing pass zeroes the block bitmap, the node kinds and the
// block counts before the first item is taken. Create and append are driven
// by first-free searches that step through a RAM read port, over the node
// kinds and over the bitmap words, plus a wipe of the new node's pointers
// when a double pointer node is taken. The result sits in an output
// register, so the next item is taken while it waits.
// ----------------------------------------------------------------------------
module inode_block_map_allocator_core (
   input  wire logic    clock,
   input  wire logic    reset,
   ibma_req_if.sink     req_ch,
   ibma_rsp_if.source   rsp_ch
);

   localparam int NW  = ibma_pkg::NODE_W;
   localparam int BW  = ibma_pkg::BLOCK_W;
   localparam int SW  = ibma_pkg::SLOT_W;
   localparam int CW  = ibma_pkg::CNT_W;
   localparam int LW  = ibma_pkg::LB_W;
   localparam int MW  = ibma_pkg::MAP_WORD_W;
   localparam int MBW = ibma_pkg::MAP_BIT_W;
   localparam int MAW = ibma_pkg::MAP_AW;
   localparam int PAW = ibma_pkg::PTR_AW;
   localparam int PDW = ibma_pkg::PTR_DW;
   localparam int QW  = ibma_pkg::SCAN_W;

   ibma_pkg::state_type state_ff, state_in;

   logic [QW-1:0]  scan_ff, scan_in;
   logic [1:0]     cmd_ff, cmd_in;
   logic [NW-1:0]  ino_ff, ino_in;
   logic [LW-1:0]  lb_ff, lb_in;
   logic [CW-1:0]  cnt_ff, cnt_in;
   ibma_pkg::path_type path_ff, path_in;
   logic [1:0]     lvl_ff, lvl_in;
   logic [NW-1:0]  cur_ff, cur_in;
   logic [1:0]     need_ff, need_in;
   logic [NW-1:0]  n1_ff, n1_in;
   logic [NW-1:0]  n2_ff, n2_in;
   logic           nfound_ff, nfound_in;
   logic [BW-1:0]  blk_ff, blk_in;
   logic [MW-1:0]  bword_ff, bword_in;
   logic [2:0]     status_ff, status_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [BW-1:0]  rsp_block_ff, rsp_block_in;
   logic [NW-1:0]  rsp_node_ff, rsp_node_in;
   logic [2:0]     rsp_status_ff, rsp_status_in;

   logic           bm_we, kd_we, ct_we, pt_we;
   logic [MAW-1:0] bm_waddr, bm_raddr;
   logic [MW-1:0]  bm_wdata, bm_rdata;
   logic [NW-1:0]  kd_waddr, kd_raddr, ct_waddr, ct_raddr;
   logic [1:0]     kd_wdata, kd_rdata;
   logic [CW-1:0]  ct_wdata, ct_rdata;
   logic [PAW-1:0] pt_waddr, pt_raddr;
   logic [PDW-1:0] pt_wdata, pt_rdata;

   logic           word_free;
   logic [MBW-1:0] free_bit;
   logic           is_lookup, is_create, last_lvl, kind_bad, out_of_range, ptr_ok;
   logic           can_load;
   logic [LW-1:0]  target;
   logic [SW-1:0]  slot_sel;

   ibma_ram #(.WIDTH(MW), .DEPTH(ibma_pkg::MAP_DEPTH)) u_map (
      .clock, .wr_en(bm_we), .wr_addr(bm_waddr), .wr_data(bm_wdata),
      .rd_addr(bm_raddr), .rd_data(bm_rdata));

   ibma_ram #(.WIDTH(2), .DEPTH(ibma_pkg::NODE_COUNT)) u_kind (
      .clock, .wr_en(kd_we), .wr_addr(kd_waddr), .wr_data(kd_wdata),
      .rd_addr(kd_raddr), .rd_data(kd_rdata));

   ibma_ram #(.WIDTH(CW), .DEPTH(ibma_pkg::NODE_COUNT)) u_count (
      .clock, .wr_en(ct_we), .wr_addr(ct_waddr), .wr_data(ct_wdata),
      .rd_addr(ct_raddr), .rd_data(ct_rdata));

   ibma_ram #(.WIDTH(PDW), .DEPTH(ibma_pkg::PTR_DEPTH)) u_ptr (
      .clock, .wr_en(pt_we), .wr_addr(pt_waddr), .wr_data(pt_wdata),
      .rd_addr(pt_raddr), .rd_data(pt_rdata));

   ibma_ffz #(.WIDTH(MW)) u_ffz (
      .word(bm_rdata), .found(word_free), .index(free_bit));

   assign is_lookup    = (cmd_ff == ibma_pkg::CMD_LOOKUP);
   assign is_create    = (cmd_ff == ibma_pkg::CMD_CREATE);
   assign last_lvl     = (lvl_ff == 2'(path_ff.depth - 2'd1));
   assign kind_bad     = (kd_rdata != ibma_pkg::KIND_INODE);
   assign target       = is_lookup ? lb_ff : ct_rdata;
   assign out_of_range = is_lookup ?
                         ((lb_ff >= ct_rdata) || (lb_ff >= LW'(ibma_pkg::CAPACITY))) :
                         (ct_rdata >= CW'(ibma_pkg::CAPACITY));
   assign ptr_ok       = pt_rdata[PDW-1];
   assign can_load     = !rsp_valid_ff || rsp_ch.ready;

   always_comb begin
      case (lvl_ff)
         2'd0:    slot_sel = path_ff.slot0;
         2'd1:    slot_sel = path_ff.slot1;
         default: slot_sel = path_ff.slot2;
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ibma_pkg::S_CLEAR: begin
            if (scan_ff == QW'(ibma_pkg::MAP_DEPTH - 1)) state_in = ibma_pkg::S_IDLE;
         end
         ibma_pkg::S_IDLE: begin
            if (req_ch.valid) begin
               case (req_ch.command) inside
                  ibma_pkg::CMD_CREATE:                       state_in = ibma_pkg::S_NODE_RD;
                  ibma_pkg::CMD_APPEND, ibma_pkg::CMD_LOOKUP: state_in = ibma_pkg::S_INFO_RD;
                  default:                                    state_in = ibma_pkg::S_FIN;
               endcase
            end
         end
         ibma_pkg::S_INFO_RD: state_in = ibma_pkg::S_INFO_CHK;
         ibma_pkg::S_INFO_CHK: begin
            if (kind_bad || out_of_range) state_in = ibma_pkg::S_FIN;
            else if (is_lookup)           state_in = ibma_pkg::S_WALK_RD;
            else                          state_in = ibma_pkg::S_BLK_RD;
         end
         ibma_pkg::S_BLK_RD: state_in = ibma_pkg::S_BLK_CHK;
         ibma_pkg::S_BLK_CHK: begin
            if (word_free)
               state_in = is_create ? ibma_pkg::S_CR_COMMIT : ibma_pkg::S_WALK_RD;
            else if (scan_ff == QW'(ibma_pkg::MAP_DEPTH - 1))
               state_in = ibma_pkg::S_FIN;
            else
               state_in = ibma_pkg::S_BLK_RD;
         end
         ibma_pkg::S_NODE_RD: begin
            if (scan_ff == QW'(ibma_pkg::NODE_COUNT)) state_in = ibma_pkg::S_FIN;
            else                                      state_in = ibma_pkg::S_NODE_CHK;
         end
         ibma_pkg::S_NODE_CHK: begin
            if (kd_rdata != ibma_pkg::KIND_UNUSED)    state_in = ibma_pkg::S_NODE_RD;
            else if (is_create)                       state_in = ibma_pkg::S_BLK_RD;
            else if (need_ff == 2'd2 && !nfound_ff)   state_in = ibma_pkg::S_NODE_RD;
            else if (need_ff == 2'd2)                 state_in = ibma_pkg::S_NODE_CLR;
            else                                      state_in = ibma_pkg::S_LINK;
         end
         ibma_pkg::S_WALK_RD: begin
            if (!is_lookup && last_lvl) state_in = ibma_pkg::S_DATA;
            else                        state_in = ibma_pkg::S_WALK_CHK;
         end
         ibma_pkg::S_WALK_CHK: begin
            if (is_lookup)
               state_in = (!ptr_ok || last_lvl) ? ibma_pkg::S_FIN : ibma_pkg::S_WALK_RD;
            else
               state_in = ptr_ok ? ibma_pkg::S_WALK_RD : ibma_pkg::S_NODE_RD;
         end
         ibma_pkg::S_NODE_CLR: begin
            if (scan_ff == QW'(ibma_pkg::POINTERS_PER_NODE - 1)) state_in = ibma_pkg::S_LINK;
         end
         ibma_pkg::S_LINK: begin
            if (need_ff == 2'd1) state_in = ibma_pkg::S_DATA;
         end
         ibma_pkg::S_DATA:      state_in = ibma_pkg::S_FIN;
         ibma_pkg::S_CR_COMMIT: state_in = ibma_pkg::S_CR_CLR;
         ibma_pkg::S_CR_CLR: begin
            if (scan_ff == QW'(ibma_pkg::DIRECT_SLOTS + ibma_pkg::SINGLE_SLOTS +
                               ibma_pkg::DOUBLE_SLOTS - 1))
               state_in = ibma_pkg::S_FIN;
         end
         ibma_pkg::S_FIN: begin
            if (can_load) state_in = ibma_pkg::S_IDLE;
         end
         default: state_in = ibma_pkg::S_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      scan_in       = scan_ff;
      cmd_in        = cmd_ff;
      ino_in        = ino_ff;
      lb_in         = lb_ff;
      cnt_in        = cnt_ff;
      path_in       = path_ff;
      lvl_in        = lvl_ff;
      cur_in        = cur_ff;
      need_in       = need_ff;
      n1_in         = n1_ff;
      n2_in         = n2_ff;
      nfound_in     = nfound_ff;
      blk_in        = blk_ff;
      bword_in      = bword_ff;
      status_in     = status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_block_in  = rsp_block_ff;
      rsp_node_in   = rsp_node_ff;
      rsp_status_in = rsp_status_ff;
      bm_we = 1'b0; bm_waddr = '0; bm_wdata = '0; bm_raddr = '0;
      kd_we = 1'b0; kd_waddr = '0; kd_wdata = '0; kd_raddr = '0;
      ct_we = 1'b0; ct_waddr = '0; ct_wdata = '0; ct_raddr = '0;
      pt_we = 1'b0; pt_waddr = '0; pt_wdata = '0; pt_raddr = '0;
      unique case (state_ff)
         ibma_pkg::S_CLEAR: begin
            bm_we    = 1'b1;
            bm_waddr = scan_ff[MAW-1:0];
            kd_we    = 1'b1;
            kd_waddr = scan_ff[NW-1:0];
            ct_we    = 1'b1;
            ct_waddr = scan_ff[NW-1:0];
            scan_in  = QW'(scan_ff + 1'b1);
         end
         ibma_pkg::S_IDLE: begin
            if (req_ch.valid) begin
               cmd_in    = req_ch.command;
               ino_in    = req_ch.inode_index;
               lb_in     = req_ch.logical_block;
               scan_in   = '0;
               nfound_in = 1'b0;
               need_in   = 2'd0;
               status_in = ibma_pkg::ST_RANGE;
            end
         end
         ibma_pkg::S_INFO_RD: begin
            kd_raddr = ino_ff;
            ct_raddr = ino_ff;
         end
         ibma_pkg::S_INFO_CHK: begin
            cnt_in  = ct_rdata;
            path_in = ibma_pkg::path_of(target);
            lvl_in  = 2'd0;
            cur_in  = ino_ff;
            scan_in = '0;
            if (kind_bad)          status_in = ibma_pkg::ST_NOT_INODE;
            else if (out_of_range) status_in = ibma_pkg::ST_RANGE;
         end
         ibma_pkg::S_BLK_RD: begin
            bm_raddr = scan_ff[MAW-1:0];
         end
         ibma_pkg::S_BLK_CHK: begin
            if (word_free) begin
               blk_in   = {scan_ff[MAW-1:0], free_bit};
               bword_in = bm_rdata;
            end else if (scan_ff == QW'(ibma_pkg::MAP_DEPTH - 1)) begin
               status_in = ibma_pkg::ST_NO_BLOCK;
            end else begin
               scan_in = QW'(scan_ff + 1'b1);
            end
         end
         ibma_pkg::S_NODE_RD: begin
            kd_raddr = scan_ff[NW-1:0];
            if (scan_ff == QW'(ibma_pkg::NODE_COUNT)) status_in = ibma_pkg::ST_NO_NODE;
         end
         ibma_pkg::S_NODE_CHK: begin
            if (kd_rdata == ibma_pkg::KIND_UNUSED) begin
               if (!nfound_ff) n1_in = scan_ff[NW-1:0];
               else            n2_in = scan_ff[NW-1:0];
               nfound_in = 1'b1;
               scan_in   = (need_ff == 2'd2 && !nfound_ff) ? QW'(scan_ff + 1'b1) : '0;
            end else begin
               scan_in = QW'(scan_ff + 1'b1);
            end
         end
         ibma_pkg::S_WALK_RD: begin
            pt_raddr = {cur_ff, slot_sel};
         end
         ibma_pkg::S_WALK_CHK: begin
            if (is_lookup) begin
               if (!ptr_ok) begin
                  status_in = ibma_pkg::ST_RANGE;
               end else if (last_lvl) begin
                  blk_in    = pt_rdata[BW-1:0];
                  status_in = ibma_pkg::ST_OK;
               end else begin
                  cur_in = pt_rdata[NW-1:0];
                  lvl_in = 2'(lvl_ff + 2'd1);
               end
            end else if (!ptr_ok) begin
               need_in   = 2'(path_ff.depth - 2'd1 - lvl_ff);
               scan_in   = '0;
               nfound_in = 1'b0;
            end else begin
               cur_in = pt_rdata[NW-1:0];
               lvl_in = 2'(lvl_ff + 2'd1);
            end
         end
         ibma_pkg::S_NODE_CLR: begin
            pt_we    = 1'b1;
            pt_waddr = {n1_ff, scan_ff[SW-1:0]};
            scan_in  = QW'(scan_ff + 1'b1);
         end
         ibma_pkg::S_LINK: begin
            kd_we    = 1'b1;
            kd_waddr = n1_ff;
            kd_wdata = (need_ff == 2'd2) ? ibma_pkg::KIND_DNODE : ibma_pkg::KIND_PNODE;
            pt_we    = 1'b1;
            pt_waddr = {cur_ff, slot_sel};
            pt_wdata = {1'b1, BW'(n1_ff)};
            cur_in   = n1_ff;
            lvl_in   = 2'(lvl_ff + 2'd1);
            need_in  = 2'(need_ff - 2'd1);
            n1_in    = n2_ff;
         end
         ibma_pkg::S_DATA: begin
            pt_we     = 1'b1;
            pt_waddr  = {cur_ff, slot_sel};
            pt_wdata  = {1'b1, blk_ff};
            bm_we     = 1'b1;
            bm_waddr  = blk_ff[BW-1:MBW];
            bm_wdata  = bword_ff | (MW'(1) << blk_ff[MBW-1:0]);
            ct_we     = 1'b1;
            ct_waddr  = ino_ff;
            ct_wdata  = CW'(cnt_ff + 1'b1);
            status_in = ibma_pkg::ST_OK;
         end
         ibma_pkg::S_CR_COMMIT: begin
            bm_we     = 1'b1;
            bm_waddr  = blk_ff[BW-1:MBW];
            bm_wdata  = bword_ff | (MW'(1) << blk_ff[MBW-1:0]);
            kd_we     = 1'b1;
            kd_waddr  = n1_ff;
            kd_wdata  = ibma_pkg::KIND_INODE;
            ct_we     = 1'b1;
            ct_waddr  = n1_ff;
            ct_wdata  = CW'(1);
            pt_we     = 1'b1;
            pt_waddr  = {n1_ff, SW'(0)};
            pt_wdata  = {1'b1, blk_ff};
            scan_in   = QW'(ibma_pkg::DIRECT_SLOTS);
            status_in = ibma_pkg::ST_OK;
         end
         ibma_pkg::S_CR_CLR: begin
            pt_we    = 1'b1;
            pt_waddr = {n1_ff, scan_ff[SW-1:0]};
            scan_in  = QW'(scan_ff + 1'b1);
         end
         ibma_pkg::S_FIN: begin
            if (can_load) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_block_in  = (status_ff == ibma_pkg::ST_OK) ? blk_ff : '0;
               if (is_create)
                  rsp_node_in = (status_ff == ibma_pkg::ST_OK) ? n1_ff : '0;
               else
                  rsp_node_in = ino_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ibma_pkg::S_CLEAR;
         scan_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         scan_ff      <= scan_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      ino_ff        <= ino_in;
      lb_ff         <= lb_in;
      cnt_ff        <= cnt_in;
      path_ff       <= path_in;
      lvl_ff        <= lvl_in;
      cur_ff        <= cur_in;
      need_ff       <= need_in;
      n1_ff         <= n1_in;
      n2_ff         <= n2_in;
      nfound_ff     <= nfound_in;
      blk_ff        <= blk_in;
      bword_ff      <= bword_in;
      status_ff     <= status_in;
      rsp_block_ff  <= rsp_block_in;
      rsp_node_ff   <= rsp_node_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign req_ch.ready          = (state_ff == ibma_pkg::S_IDLE);
   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.physical_block = rsp_block_ff;
   assign rsp_ch.node_number    = rsp_node_ff;
   assign rsp_ch.status         = rsp_status_ff;

endmodule
`default_nettype wire
